// ===== hw/rtl/bds_pkg.sv =====
`timescale 1ns / 1ps
// Package for the baud divisor search core: payload structs, control structs
// and fixed arithmetic constants. No dependencies.
package bds_pkg;

    // Request and response payloads
    typedef struct packed {
        logic [1:0]  port;
        logic [19:0] baud_rate;
    } bds_in_t;

    typedef struct packed {
        logic [1:0] port_echo;
        logic [1:0] clock_select;
        logic [7:0] divisor;
        logic       failed;
    } bds_out_t;

    // Widths
    localparam int CLK_W   = 9;
    localparam int BAUD_W  = 20;
    localparam int NUM_W   = 33;           // clk * 10^7 fits in 33 bits
    localparam int CNT_W   = 6;
    localparam int T_W     = NUM_W - 5;    // quotient after the smallest basis shift
    localparam int Q_W     = 12;           // rounding sum width
    localparam int PROD_W  = 28;

    // Arithmetic constants
    localparam logic [23:0]      CLK_SCALE   = 24'd10000000;
    localparam logic [CNT_W-1:0] DIV_LAST    = CNT_W'(NUM_W - 1);
    // floor(n/32/4^c) must lie in [5, 2564] for q = (t+5)/10 to land in 1..256
    localparam logic [T_W-1:0]   T_MIN       = T_W'(5);
    localparam logic [T_W-1:0]   T_MAX       = T_W'(2564);
    localparam logic [Q_W-1:0]   ROUND_ADD   = Q_W'(5);
    // x/10 == (x * 52429) >> 19 for every x below 43699
    localparam logic [15:0]      RECIP10     = 16'd52429;
    localparam int               RECIP_SHIFT = 19;
    localparam logic [1:0]       CODE_LAST   = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic       load;
        logic       div_step;
        logic       check;
        logic [1:0] code;
        logic       out_write;
    } bds_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic fit;
        logic bad;
        logic out_busy;
    } bds_sts_t;

endpackage

// ===== hw/rtl/bds_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the baud divisor search: clock register, bit-serial divider,
// prescaler fit check and output register. Depends on bds_pkg.
module bds_datapath
    import bds_pkg::*;
#(
    parameter int PORTS = 4
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  logic [CLK_W-1:0] cfg_wr_data,
    input  bds_in_t         s_data,
    input  logic            m_ready,
    output logic            m_valid,
    output bds_out_t        m_data,
    input  bds_cmd_t        cmd,
    output bds_sts_t        sts
);

    localparam logic [2:0] PORTS_LIM = 3'(PORTS);

    logic [CLK_W-1:0]  clk_mhz_reg;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [BAUD_W-1:0] rem_reg, rem_next;
    logic [BAUD_W-1:0] baud_reg;
    logic [1:0]        port_reg;
    logic              bad_reg;
    bds_out_t          res_reg;
    bds_out_t          out_reg;
    logic              m_valid_reg;

    logic [BAUD_W:0]   shifted;
    logic [BAUD_W:0]   diff;
    logic [T_W-1:0]    t_val;
    logic [Q_W-1:0]    q_sum;
    logic [PROD_W-1:0] prod;
    logic [8:0]        q_val;
    logic              fit;

    // Shared clock register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clk_mhz_reg <= '0;
        end else if (cfg_wr_en) begin
            clk_mhz_reg <= cfg_wr_data;
        end
    end

    // Restoring divider step: one quotient bit per cycle into num_reg
    always_comb begin
        shifted  = {rem_reg, num_reg[NUM_W-1]};
        diff     = shifted - {1'b0, baud_reg};
        num_next = num_reg;
        rem_next = rem_reg;
        if (cmd.load) begin
            num_next = NUM_W'(clk_mhz_reg) * NUM_W'(CLK_SCALE);
            rem_next = '0;
        end else if (cmd.div_step) begin
            if (!diff[BAUD_W]) begin
                rem_next = diff[BAUD_W-1:0];
                num_next = {num_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[BAUD_W-1:0];
                num_next = {num_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        if (cmd.load) begin
            baud_reg <= s_data.baud_rate;
            port_reg <= s_data.port;
            bad_reg  <= (s_data.baud_rate == '0) || ({1'b0, s_data.port} >= PORTS_LIM);
        end
    end

    // Prescaler fit: divide quotient by the basis, round, scale by 1/10
    always_comb begin
        unique case (cmd.code)
            2'd0:    t_val = num_reg[NUM_W-1:5];
            2'd1:    t_val = T_W'(num_reg[NUM_W-1:7]);
            2'd2:    t_val = T_W'(num_reg[NUM_W-1:9]);
            default: t_val = T_W'(num_reg[NUM_W-1:11]);
        endcase
        fit   = (t_val >= T_MIN) && (t_val <= T_MAX);
        q_sum = t_val[Q_W-1:0] + ROUND_ADD;
        prod  = PROD_W'(q_sum) * PROD_W'(RECIP10);
        q_val = prod[PROD_W-1:RECIP_SHIFT];
    end

    // Result of the latest check
    always_ff @(posedge aclk) begin
        if (cmd.check) begin
            res_reg.port_echo <= port_reg;
            if (fit && !bad_reg) begin
                res_reg.clock_select <= cmd.code;
                res_reg.divisor      <= 8'(q_val - 9'd1);
                res_reg.failed       <= 1'b0;
            end else begin
                res_reg.clock_select <= '0;
                res_reg.divisor      <= '0;
                res_reg.failed       <= 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_write) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_write) begin
            out_reg <= res_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_data       = out_reg;
    assign sts.fit      = fit;
    assign sts.bad      = bad_reg;
    assign sts.out_busy = m_valid_reg && !m_ready;

endmodule

// ===== hw/rtl/bds_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the baud divisor search: sequences load, divider steps,
// prescaler checks and the output write. Depends on bds_pkg.
module bds_ctrl
    import bds_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output bds_cmd_t cmd,
    input  bds_sts_t sts
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DIV    = 4'b0010,
        ST_CHECK  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       code_reg, code_next;

    // Next state and commands
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        code_next     = code_reg;
        s_ready       = 1'b0;
        cmd           = '0;
        cmd.code      = code_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = DIV_LAST;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0) begin
                    code_next  = '0;
                    state_next = ST_CHECK;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_CHECK: begin
                cmd.check = 1'b1;
                if (sts.fit || sts.bad || (code_reg == CODE_LAST)) begin
                    state_next = ST_FINISH;
                end else begin
                    code_next = code_reg + 1'b1;
                end
            end
            ST_FINISH: begin
                if (!sts.out_busy) begin
                    cmd.out_write = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            code_reg  <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            code_reg  <= code_next;
        end
    end

    // Output register is never overwritten while its transaction is pending
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_write |-> !sts.out_busy)
        else $error("output written while a transaction is pending");

    // Accepted request starts the divider on the next cycle with a full count
    a_start_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_DIV) && (cnt_reg == DIV_LAST))
        else $error("divider not started after accept");

    // Checks only follow a completed division
    a_check_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.check && (code_reg == '0)) |-> ($past(cmd.div_step) && $past(cnt_reg) == '0))
        else $error("check started before division finished");

endmodule

// ===== hw/rtl/baud_divisor_search_core.sv =====
`timescale 1ns / 1ps
// A request is taken only while the core is idle. The accepting cycle loads
// clk*10^7, the bit-serial restoring divider then computes the 33-bit quotient
// (one quotient bit a cycle), prescaler codes 0..3 are tested in order until
// one fits, the request is found bad or code 3 has been tried, and a final
// state moves the answer into the output register. That move waits while the
// previous result is still pending in the output register. A new request is
// accepted once the previous one has moved to the output register, even if
// that result has not been taken yet.
// Top level: instantiates bds_ctrl and bds_datapath; depends on bds_pkg.
module baud_divisor_search_core
    import bds_pkg::*;
#(
    parameter int PORTS = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [CLK_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  bds_in_t          s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output bds_out_t         m_data
);

    bds_cmd_t cmd;
    bds_sts_t sts;

    // Sequencer
    bds_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // Arithmetic and registers
    bds_datapath #(
        .PORTS (PORTS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_data      (m_data),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule
